// ----- design/jet_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Julia escape-time package
// Shared widths, fixed-point constants, register indexes and the operand and
// product bundles of the shared multiplier unit.
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int Q_W     = 32;
  localparam int Q_FRAC  = 28;
  localparam int PROD_W  = 2 * Q_W;
  localparam int ITER_W  = 12;
  localparam int LEVEL_W = 8;
  localparam int COORD_W = 12;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int REG_IDX_W   = 3;

  localparam logic [REG_IDX_W-1:0] REG_C_REAL     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_C_IMAG     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RE_ORIGIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IM_ORIGIN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RE_STEP    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_IM_STEP    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam q_t RST_C_REAL    = 32'shF4CC_CCCD;
  localparam q_t RST_C_IMAG    = 32'sh0452_88CE;
  localparam q_t RST_RE_ORIGIN = 32'shE800_0000;
  localparam q_t RST_IM_ORIGIN = 32'shF000_0000;
  localparam q_t RST_RE_STEP   = 32'sh0003_0000;
  localparam q_t RST_IM_STEP   = 32'sh0002_0000;
  localparam logic [ITER_W-1:0] RST_ITER_LIMIT = 12'd196;

  // Escape bounds: a component above 2.0 in Q4.28, and |z|^2 above 4.0 in Q8.56.
  localparam q_t    TWO_Q  = 32'sh2000_0000;
  localparam prod_t FOUR_SQ = 64'sh0400_0000_0000_0000;

  typedef struct packed {
    q_t a0;
    q_t b0;
    q_t a1;
    q_t b1;
    q_t a2;
    q_t b2;
  } mul_ops_t;

  typedef struct packed {
    prod_t p0;
    prod_t p1;
    prod_t p2;
  } mul_prods_t;

endpackage

// ----- design/jet_cmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier unit
// Three signed 32x32 multipliers with registered products. The sequencer uses
// them for the pixel mapping and for the complex square of every iteration.
// ----------------------------------------------------------------------------
module jet_cmul (
  input  logic               clk,
  input  jet_pkg::mul_ops_t   ops,
  output jet_pkg::mul_prods_t prods
);
  import jet_pkg::*;

  mul_prods_t prods_r;
  mul_prods_t prods_nxt;

  always_comb begin
    prods_nxt.p0 = $signed(ops.a0) * $signed(ops.b0);
    prods_nxt.p1 = $signed(ops.a1) * $signed(ops.b1);
    prods_nxt.p2 = $signed(ops.a2) * $signed(ops.b2);
  end

  always_ff @(posedge clk) begin
    prods_r <= prods_nxt;
  end

  assign prods = prods_r;

endmodule

// ----- design/jet_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level divider
// Restoring radix-2 divider that produces one quotient bit per cycle. The
// divisor must stay stable and nonzero while the divider is busy.
// ----------------------------------------------------------------------------
module jet_div #(
  parameter int DW = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [jet_pkg::ITER_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [DW-1:0]               quotient
);
  import jet_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic [ITER_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [ITER_W:0] shl;
  logic [ITER_W:0] diff;
  logic            ge;

  always_comb begin
    shl  = {rem_r, quo_r[DW-1]};
    ge   = shl >= {1'b0, divisor};
    diff = shl - {1'b0, divisor};

    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[ITER_W-1:0] : shl[ITER_W-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- design/julia_escape_time_level_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Julia set escape-time level core
// Maps a pixel (col, row) to a Q4.28 start point, iterates z = z*z + c and
// returns the iteration count and the quantized escape level.
//
// Usage: one input transaction on in_* carries one pixel; exactly one output
// transaction on out_* carries its result. Constants are to be written on
// cfg_* by the user only while the core is idle; the core does not check it.
// Each iteration runs through one shared set of three multipliers in the
// states S_SQ (multiply) and S_STEP (add and escape test). When the pixel
// escapes before the limit, its level comes from the bit-serial level divider
// (DW = 12 + clog2(LEVELS + 1), 21 by default). The default iteration limit
// is 196.
// One pixel is worked on at a time: in_tready is high only while the
// sequencer is idle. A finished result waits in the output register while the
// next pixel is already accepted; if the receiver stalls, the sequencer holds
// the following result until the output register is free.
// Reset returns the sequencer to idle, drops out_tvalid and loads the default
// constants into all configuration registers.
// ----------------------------------------------------------------------------
module julia_escape_time_level_core #(
  parameter int COORD_BITS = 12,
  parameter int LEVELS     = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [jet_pkg::IN_TDATA_W-1:0]      in_tdata,   // col[11:0], row[23:12]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [jet_pkg::OUT_TDATA_W-1:0]     out_tdata,  // level[7:0], iterations[19:8], zero
  input  logic                                cfg_wr_en,
  input  logic [jet_pkg::REG_IDX_W-1:0]       cfg_addr,
  input  logic [jet_pkg::Q_W-1:0]             cfg_wr_data
);
  import jet_pkg::*;

  localparam int DIV_W = ITER_W + $clog2(LEVELS + 1);
  localparam int NX_W  = Q_W + 6;
  localparam logic [COORD_W-1:0] COORD_MASK =
    (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;
  localparam logic [2:0] S_LVL  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  q_t                cr_r, ci_r, reo_r, imo_r, res_r, ims_r;
  logic [ITER_W-1:0] lim_r;

  logic [2:0]         state_r, state_nxt;
  logic [COORD_W-1:0] col_r, col_nxt, row_r, row_nxt;
  q_t                 x_r, x_nxt, y_r, y_nxt;
  logic [ITER_W-1:0]  count_r, count_nxt;
  logic               chk_r, chk_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [LEVEL_W-1:0] out_lvl_r, out_lvl_nxt;
  logic [ITER_W-1:0]  out_iter_r, out_iter_nxt;

  mul_ops_t   ops;
  mul_prods_t prods;
  prod_t      p0, p1, p2;

  logic signed [PROD_W+1:0] re_acc;
  logic signed [NX_W-1:0]   nr, ni;
  prod_t                    sx, sy, sq_sum;
  logic                     rng_esc, sq_esc;
  logic [ITER_W-1:0]        cnt_inc;

  logic              div_start, div_busy, div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [DIV_W-1:0]  dividend;

  jet_cmul u_cmul (
    .clk   (clk),
    .ops   (ops),
    .prods (prods)
  );

  jet_div #(.DW(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (lim_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_r  <= RST_C_REAL;
      ci_r  <= RST_C_IMAG;
      reo_r <= RST_RE_ORIGIN;
      imo_r <= RST_IM_ORIGIN;
      res_r <= RST_RE_STEP;
      ims_r <= RST_IM_STEP;
      lim_r <= RST_ITER_LIMIT;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_C_REAL:     cr_r  <= cfg_wr_data;
        REG_C_IMAG:     ci_r  <= cfg_wr_data;
        REG_RE_ORIGIN:  reo_r <= cfg_wr_data;
        REG_IM_ORIGIN:  imo_r <= cfg_wr_data;
        REG_RE_STEP:    res_r <= cfg_wr_data;
        REG_IM_STEP:    ims_r <= cfg_wr_data;
        REG_ITER_LIMIT: lim_r <= cfg_wr_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign p0 = prods.p0;
  assign p1 = prods.p1;
  assign p2 = prods.p2;

  always_comb begin
    if (state_r == S_MAP) begin
      ops.a0 = $signed(Q_W'(col_r));
      ops.b0 = res_r;
      ops.a1 = $signed(Q_W'(row_r));
      ops.b1 = ims_r;
      ops.a2 = '0;
      ops.b2 = '0;
    end else begin
      ops.a0 = x_r;
      ops.b0 = x_r;
      ops.a1 = y_r;
      ops.b1 = y_r;
      ops.a2 = x_r;
      ops.b2 = y_r;
    end
  end

  always_comb begin
    sx = PROD_W'(reo_r) + p0;
    sy = PROD_W'(imo_r) + p1;

    re_acc = (PROD_W+2)'(p0) - (PROD_W+2)'(p1) + ((PROD_W+2)'(cr_r) <<< Q_FRAC);
    nr     = re_acc[PROD_W+1:Q_FRAC];
    ni     = NX_W'(p2 >>> (Q_FRAC - 1)) + NX_W'(ci_r);

    rng_esc = (nr > NX_W'(TWO_Q)) || (nr < -NX_W'(TWO_Q)) ||
              (ni > NX_W'(TWO_Q)) || (ni < -NX_W'(TWO_Q));
    sq_sum  = p0 + p1;
    sq_esc  = sq_sum > FOUR_SQ;
    cnt_inc = count_r + 1'b1;

    dividend = DIV_W'(count_r) * DIV_W'(LEVELS);
  end

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    count_nxt      = count_r;
    chk_nxt        = chk_r;
    level_nxt      = level_r;
    out_lvl_nxt    = out_lvl_r;
    out_iter_nxt   = out_iter_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    div_start      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          col_nxt   = in_tdata[COORD_W-1:0] & COORD_MASK;
          row_nxt   = in_tdata[2*COORD_W-1:COORD_W] & COORD_MASK;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sx > PROD_W'(q_t'({1'b0, {(Q_W-1){1'b1}}}))) begin
          x_nxt = {1'b0, {(Q_W-1){1'b1}}};
        end else if (sx < PROD_W'(q_t'({1'b1, {(Q_W-1){1'b0}}}))) begin
          x_nxt = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
          x_nxt = sx[Q_W-1:0];
        end
        if (sy > PROD_W'(q_t'({1'b0, {(Q_W-1){1'b1}}}))) begin
          y_nxt = {1'b0, {(Q_W-1){1'b1}}};
        end else if (sy < PROD_W'(q_t'({1'b1, {(Q_W-1){1'b0}}}))) begin
          y_nxt = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
          y_nxt = sy[Q_W-1:0];
        end
        count_nxt = '0;
        chk_nxt   = 1'b0;
        state_nxt = (lim_r == '0) ? S_LVL : S_SQ;
      end
      S_SQ: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (chk_r && sq_esc) begin
          state_nxt = S_LVL;
        end else begin
          if (chk_r) begin
            count_nxt = cnt_inc;
          end
          if (chk_r && cnt_inc == lim_r) begin
            state_nxt = S_LVL;
          end else if (rng_esc) begin
            state_nxt = S_LVL;
          end else begin
            x_nxt     = nr[Q_W-1:0];
            y_nxt     = ni[Q_W-1:0];
            chk_nxt   = 1'b1;
            state_nxt = S_SQ;
          end
        end
      end
      S_LVL: begin
        if (count_r == lim_r) begin
          level_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          level_nxt = div_quo[LEVEL_W-1:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_lvl_nxt    = level_r;
          out_iter_nxt   = count_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    count_r    <= count_nxt;
    chk_r      <= chk_nxt;
    level_r    <= level_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_iter_r <= out_iter_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-ITER_W-LEVEL_W){1'b0}}, out_iter_r, out_lvl_r};

`ifndef NO_ASSERTIONS
  a_accept_starts_map : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_MAP)
    else $error("accepted pixel did not start the mapping step");

  a_orbit_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQ && chk_r |->
      x_r <= TWO_Q && x_r >= -TWO_Q && y_r <= TWO_Q && y_r >= -TWO_Q)
    else $error("orbit point outside the escape bound was kept");

  a_div_active : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_busy || div_done)
    else $error("sequencer waits on an idle divider");

  a_result_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_FIN)
    else $error("result presented without a finished pixel");
`endif

endmodule
